// ===== hdl/rtst_pkg.sv =====
// Package with types, codes and helpers for the round-trip statistics table.
package rtst_pkg;

  localparam int MAX_PARTICIPANTS = 32;
  localparam int RTT_BITS         = 32;
  localparam int IDX_W            = (MAX_PARTICIPANTS > 1) ? $clog2(MAX_PARTICIPANTS) : 1;

  localparam logic [31:0] RTT_MASK =
    (RTT_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << RTT_BITS) - 64'd1);

  localparam logic [1:0] OP_REPORT    = 2'd0;
  localparam logic [1:0] OP_END_ROUND = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SW_RD,
    ST_SW_WR
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  participant;
    logic [31:0] best_rtt;
    logic [31:0] worst_rtt;
  } cmd_t;

  typedef struct packed {
    logic        known;
    logic [31:0] current_best;
    logic [31:0] current_worst;
    logic [31:0] all_time_worst;
    logic [31:0] missed_count;
    logic [31:0] round_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] best;
    logic [31:0] worst;
    logic [31:0] peak;
    logic [31:0] missed;
    logic [31:0] rounds;
  } entry_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== hdl/round_trip_stats_table.sv =====
// Top level of the round-trip statistics table: slot store, sequencer and update unit.
// Report, read and clear: busy while the word is in ST_EXEC; a new word is taken only when idle.
// A read result is registered from ST_EXEC into rsp with a done strobe for one cycle; the receiver cannot stall.
// End of round sweeps every slot of the table, which has one read and one write port, through ST_SW_RD
// and ST_SW_WR, busy until the last slot's ST_SW_WR. Reset clears the known and seen flags at once;
// slot contents are written in full on a slot's first report and need no reset.
module round_trip_stats_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rtst_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output rtst_pkg::rsp_t rsp
);
  import rtst_pkg::*;

  state_t                state, state_next;
  cmd_t                  cmd_q;
  entry_t                mem [MAX_PARTICIPANTS];
  entry_t                rdata;
  entry_t                wdata;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [IDX_W-1:0]      raddr;
  logic [IDX_W-1:0]      cnt, cnt_next;
  logic [IDX_W-1:0]      slot_q;
  logic                  in_range;
  logic [MAX_PARTICIPANTS-1:0] known, known_next;
  logic [MAX_PARTICIPANTS-1:0] seen, seen_next;
  logic                  done_next;
  rsp_t                  rsp_next;
  logic [31:0]           worst_m;
  logic [31:0]           best_m;
  logic [31:0]           rounds_inc;
  logic [31:0]           missed_inc;
  logic [31:0]           peak_max;
  entry_t                report_entry;
  entry_t                miss_entry;

  assign busy     = (state != ST_IDLE);
  assign slot_q   = IDX_W'(cmd_q.participant);
  assign in_range = (int'(cmd_q.participant) < MAX_PARTICIPANTS);

  // shared update unit
  always_comb begin
    best_m     = cmd_q.best_rtt & RTT_MASK;
    worst_m    = cmd_q.worst_rtt & RTT_MASK;
    rounds_inc = sat_inc(rdata.rounds);
    missed_inc = sat_inc(rdata.missed);
    peak_max   = (worst_m > rdata.peak) ? worst_m : rdata.peak;
    report_entry.best  = best_m;
    report_entry.worst = worst_m;
    if (known[slot_q]) begin
      report_entry.peak   = peak_max;
      report_entry.missed = rdata.missed;
      report_entry.rounds = rounds_inc;
    end else begin
      report_entry.peak   = worst_m;
      report_entry.missed = 32'd0;
      report_entry.rounds = 32'd1;
    end
    miss_entry.best   = 32'd0;
    miss_entry.worst  = 32'd0;
    miss_entry.peak   = rdata.peak;
    miss_entry.missed = missed_inc;
    miss_entry.rounds = rounds_inc;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (cmd.op == OP_END_ROUND) ? ST_SW_RD : ST_EXEC;
        end
      end
      ST_EXEC:  state_next = ST_IDLE;
      ST_SW_RD: state_next = ST_SW_WR;
      ST_SW_WR: begin
        state_next = (cnt == IDX_W'(MAX_PARTICIPANTS - 1)) ? ST_IDLE : ST_SW_RD;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we         = 1'b0;
    waddr      = slot_q;
    wdata      = report_entry;
    raddr      = IDX_W'(cmd.participant);
    cnt_next   = cnt;
    known_next = known;
    seen_next  = seen;
    done_next  = 1'b0;
    rsp_next   = '0;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
      end
      ST_EXEC: begin
        unique case (cmd_q.op)
          OP_REPORT: begin
            if (in_range) begin
              we                 = 1'b1;
              known_next[slot_q] = 1'b1;
              seen_next[slot_q]  = 1'b1;
            end
          end
          OP_READ: begin
            done_next = 1'b1;
            if (in_range && known[slot_q]) begin
              rsp_next.known          = 1'b1;
              rsp_next.current_best   = rdata.best;
              rsp_next.current_worst  = rdata.worst;
              rsp_next.all_time_worst = rdata.peak;
              rsp_next.missed_count   = rdata.missed;
              rsp_next.round_count    = rdata.rounds;
            end
          end
          OP_CLEAR: begin
            known_next = '0;
            seen_next  = '0;
          end
          OP_END_ROUND: begin
          end
          default: begin
          end
        endcase
      end
      ST_SW_RD: begin
        raddr = cnt;
      end
      ST_SW_WR: begin
        raddr = cnt;
        waddr = cnt;
        wdata = miss_entry;
        we    = known[cnt] && !seen[cnt];
        seen_next[cnt] = 1'b0;
        cnt_next = cnt + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd_q <= cmd;
    end
    rsp <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      known <= '0;
      seen  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      known <= known_next;
      seen  <= seen_next;
      done  <= done_next;
    end
  end

`ifndef SYNTH
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_EXEC && $past(cmd_q.op) == OP_READ))
    else $error("result strobe without a read");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_seen_known: assert property (@(posedge clk) disable iff (rst)
    (seen & ~known) == '0)
    else $error("slot seen this round but not known");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the round-trip statistics table.
`timescale 1ns / 1ps

module testbench;
  import rtst_pkg::*;

  class rtt_table_tracker;
    bit          known [MAX_PARTICIPANTS];
    bit          seen  [MAX_PARTICIPANTS];
    logic [31:0] best  [MAX_PARTICIPANTS];
    logic [31:0] worst [MAX_PARTICIPANTS];
    logic [31:0] peak  [MAX_PARTICIPANTS];
    logic [31:0] missed[MAX_PARTICIPANTS];
    logic [31:0] rounds[MAX_PARTICIPANTS];
    rsp_t        pending_reads[$];
    int          mismatches;

    function new();
      wipe();
      mismatches = 0;
    endfunction

    function void wipe();
      for (int i = 0; i < MAX_PARTICIPANTS; i++) begin
        known[i]  = 1'b0;
        seen[i]   = 1'b0;
        best[i]   = '0;
        worst[i]  = '0;
        peak[i]   = '0;
        missed[i] = '0;
        rounds[i] = '0;
      end
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function void note_command(cmd_t c);
      int          slot;
      logic [31:0] b;
      logic [31:0] w;
      rsp_t        stats;
      slot = int'(c.participant);
      b = c.best_rtt & RTT_MASK;
      w = c.worst_rtt & RTT_MASK;
      case (c.op)
        OP_REPORT: begin
          if (slot < MAX_PARTICIPANTS) begin
            best[slot]  = b;
            worst[slot] = w;
            if (!known[slot]) begin
              known[slot]  = 1'b1;
              missed[slot] = '0;
              rounds[slot] = 32'd1;
              peak[slot]   = w;
            end else begin
              rounds[slot] = bump(rounds[slot]);
              if (w > peak[slot]) peak[slot] = w;
            end
            seen[slot] = 1'b1;
          end
        end
        OP_END_ROUND: begin
          for (int i = 0; i < MAX_PARTICIPANTS; i++) begin
            if (known[i] && !seen[i]) begin
              best[i]   = '0;
              worst[i]  = '0;
              missed[i] = bump(missed[i]);
              rounds[i] = bump(rounds[i]);
            end
            seen[i] = 1'b0;
          end
        end
        OP_READ: begin
          stats = '0;
          if (slot < MAX_PARTICIPANTS && known[slot]) begin
            stats.known          = 1'b1;
            stats.current_best   = best[slot];
            stats.current_worst  = worst[slot];
            stats.all_time_worst = peak[slot];
            stats.missed_count   = missed[slot];
            stats.round_count    = rounds[slot];
          end
          pending_reads.push_back(stats);
        end
        default: wipe();
      endcase
    endfunction

    function void flag(string what, logic [31:0] exp_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", what, exp_v, got_v);
    endfunction

    function void check_stats(rsp_t got);
      rsp_t exp_r;
      if (pending_reads.size() == 0) begin
        flag("unexpected word, known", 32'd0, 32'(got.known));
        return;
      end
      exp_r = pending_reads.pop_front();
      if (got.known !== exp_r.known) flag("known", 32'(exp_r.known), 32'(got.known));
      if (got.current_best !== exp_r.current_best)
        flag("current_best", exp_r.current_best, got.current_best);
      if (got.current_worst !== exp_r.current_worst)
        flag("current_worst", exp_r.current_worst, got.current_worst);
      if (got.all_time_worst !== exp_r.all_time_worst)
        flag("all_time_worst", exp_r.all_time_worst, got.all_time_worst);
      if (got.missed_count !== exp_r.missed_count)
        flag("missed_count", exp_r.missed_count, got.missed_count);
      if (got.round_count !== exp_r.round_count)
        flag("round_count", exp_r.round_count, got.round_count);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic done;
  rsp_t rsp;

  rtt_table_tracker tracker = new();
  int  words_sent = 0;
  bit  gaps_on = 1'b1;

  round_trip_stats_table dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_stats(rsp);
      if (start && !busy) tracker.note_command(cmd);
    end
  end

  function logic [31:0] rand_rtt();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1000);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [1:0] op, int slot, logic [31:0] b, logic [31:0] w);
    int   gap;
    cmd_t c;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    c.op          = op;
    c.participant = 5'(slot);
    c.best_rtt    = b;
    c.worst_rtt   = w;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  initial begin
    int acts;
    int span;
    int pick;
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(OP_READ, 0, $urandom, $urandom);
    send(OP_READ, 31, $urandom, $urandom);
    send(OP_REPORT, 0, 32'd0, 32'd0);
    send(OP_REPORT, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_READ, 0, 32'd0, 32'd0);
    send(OP_READ, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_REPORT, 0, 32'd2, 32'd5);
    send(OP_REPORT, 0, 32'd1, 32'd3);
    send(OP_READ, 0, $urandom, $urandom);
    send(OP_END_ROUND, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_READ, 31, $urandom, $urandom);
    send(OP_END_ROUND, 0, 32'd0, 32'd0);
    send(OP_READ, 0, $urandom, $urandom);
    send(OP_READ, 31, $urandom, $urandom);
    send(OP_REPORT, 5, 32'hAAAA_AAAA, 32'h5555_5555);
    send(OP_READ, 5, $urandom, $urandom);
    send(OP_CLEAR, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_READ, 0, $urandom, $urandom);
    send(OP_READ, 5, $urandom, $urandom);
    send(OP_END_ROUND, 0, 32'd0, 32'd0);
    send(OP_READ, 31, $urandom, $urandom);
    send(OP_REPORT, 0, 32'h5555_5555, 32'hAAAA_AAAA);
    send(OP_READ, 0, $urandom, $urandom);

    while (words_sent < 1820) begin
      if ($urandom_range(0, 3) == 0) gaps_on = !gaps_on;
      span = ($urandom_range(0, 1) != 0) ? 7 : MAX_PARTICIPANTS - 1;
      acts = $urandom_range(1, 14);
      for (int k = 0; k < acts; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)
          send(OP_REPORT, $urandom_range(0, span), rand_rtt(), rand_rtt());
        else if (pick < 98)
          send(OP_READ, $urandom_range(0, MAX_PARTICIPANTS - 1), $urandom, $urandom);
        else if (pick < 99)
          send(OP_CLEAR, $urandom_range(0, 31), $urandom, $urandom);
        else
          send(OP_END_ROUND, $urandom_range(0, 31), $urandom, $urandom);
      end
      send(OP_END_ROUND, $urandom_range(0, 31), $urandom, $urandom);
    end
    start <= 1'b0;

    while (tracker.pending_reads.size() != 0) @(posedge clk);
    repeat (2 * MAX_PARTICIPANTS + 16) @(posedge clk);
    tracker.mismatches += tracker.pending_reads.size();
    if (tracker.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
